@@ rtl/sle_pkg.sv @@
// Shared types and constants of the sorted list engine.
// Used by the channel interfaces, the cells, the scan logic and the top level.
package sle_pkg;

  // Fixed payload widths of the request and response items.
  localparam int CMD_W    = 3;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 4;
  localparam int LEN_W    = 5;

  // Command codes carried by a request item.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT    = 3'd0,
    CMD_REM_HEAD  = 3'd1,
    CMD_REM_TAIL  = 3'd2,
    CMD_REM_VALUE = 3'd3,
    CMD_FIND      = 3'd4
  } cmd_t;

  // Status codes carried by a response item.
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  // Control sequencer states.
  typedef enum logic {
    S_IDLE  = 1'b0,
    S_APPLY = 1'b1
  } state_t;

  // Shift orders broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic remove;
  } cell_upd_t;

endpackage

@@ rtl/sle_req_if.sv @@
// Request channel of the sorted list engine: valid/ready plus command and value.
// Depends on sle_pkg for the payload widths.
interface sle_req_if import sle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

@@ rtl/sle_rsp_if.sv @@
// Response channel of the sorted list engine: valid/ready plus the result fields.
// Depends on sle_pkg for the payload widths.
interface sle_rsp_if import sle_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] removed_value;
  logic [POS_W-1:0]        position;
  logic [LEN_W-1:0]        length;

  modport source (output valid, output status, output removed_value, output position,
                  output length, input ready);
  modport sink (input valid, input status, input removed_value, input position,
                input length, output ready);
endinterface

@@ rtl/sorted_list_engine.sv @@
// Sorted list engine: a chain of DEPTH cells keeps signed values in order.
// Every cell compares in the accept cycle and registers its flag; the chain then scans
// and shifts in the apply step, which registers the result. No new item is taken
// until the apply step is done, and a waiting result holds the apply step. Reset
// clears the count, mode, cell flags and handshake; cell entries are left as they
// are and only entries below the count are ever read.
module sorted_list_engine import sle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  sle_req_if.sink  request,
  sle_rsp_if.source response,
  input  logic     cfg_wr_en,
  input  logic     cfg_wr_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  state_t                  state;
  state_t                  state_next;
  cmd_t                    cmd_hold;
  logic signed [VAL_W-1:0] value_hold;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_next;
  logic                    descending;

  logic                    accept;
  logic                    slot_free;
  logic                    apply_go;
  cell_upd_t               upd;
  status_t                 status_sel;
  logic [IW-1:0]           pos_sel;
  logic signed [VAL_W-1:0] removed_sel;
  logic [IW+POS_W-1:0]     pos_wide;
  logic [CW+LEN_W-1:0]     len_wide;

  logic                    rsp_valid;
  status_t                 rsp_status;
  logic signed [VAL_W-1:0] rsp_removed;
  logic [POS_W-1:0]        rsp_position;
  logic [LEN_W-1:0]        rsp_length;

  logic [DEPTH-1:0]        valid_vec;
  logic [DEPTH-1:0]        flags;
  logic [DEPTH-1:0]        first;
  logic [DEPTH-1:0]        incl;
  logic                    any;
  logic [IW-1:0]           scan_pos;
  logic signed [VAL_W-1:0] scan_value;
  logic signed [VAL_W-1:0] values [DEPTH];
  logic signed [VAL_W-1:0] left_values [DEPTH];
  logic signed [VAL_W-1:0] right_values [DEPTH];
  logic [DEPTH-1:0]        valid_right;

  assign accept    = request.valid && request.ready;
  assign slot_free = !rsp_valid || response.ready;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_wr_en) begin
      descending <= cfg_wr_data;
    end
  end

  // Sequencer: next state.
  always_comb begin
    case (state)
      S_IDLE:  state_next = accept ? S_APPLY : S_IDLE;
      S_APPLY: state_next = slot_free ? S_IDLE : S_APPLY;
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    case (state)
      S_IDLE: begin
        request.ready = 1'b1;
        apply_go      = 1'b0;
      end
      S_APPLY: begin
        request.ready = 1'b0;
        apply_go      = slot_free;
      end
      default: begin
        request.ready = 1'b0;
        apply_go      = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the accepted item for the apply step.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_hold   <= cmd_t'(request.command);
      value_hold <= request.value;
    end
  end

  // Occupied cells form a run from the head, given by the count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid_vec[i] = count > CW'(i);
    end
  end

  // Neighbour wiring of the chain; the ends see an empty neighbour.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      left_values[i]  = (i == 0) ? '0 : values[(i == 0) ? 0 : i - 1];
      right_values[i] = (i == DEPTH - 1) ? '0 : values[(i == DEPTH - 1) ? i : i + 1];
      valid_right[i]  = (i == DEPTH - 1) ? 1'b0
                                         : valid_vec[(i == DEPTH - 1) ? i : i + 1];
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      sle_cell u_cell (
        .clk         (clk),
        .rst         (rst),
        .load        (accept),
        .command     (cmd_t'(request.command)),
        .key         (request.value),
        .descending  (descending),
        .valid       (valid_vec[g]),
        .valid_right (valid_right[g]),
        .upd         (upd),
        .first       (first[g]),
        .incl        (incl[g]),
        .left_value  (left_values[g]),
        .right_value (right_values[g]),
        .ins_value   (value_hold),
        .value       (values[g]),
        .flag        (flags[g])
      );
    end
  endgenerate

  sle_scan #(.DEPTH(DEPTH)) u_scan (
    .flags     (flags),
    .values    (values),
    .first     (first),
    .incl      (incl),
    .any       (any),
    .position  (scan_pos),
    .hit_value (scan_value)
  );

  // Decide the outcome of the held command from the scan.
  always_comb begin
    upd         = '0;
    status_sel  = STAT_OK;
    pos_sel     = '0;
    removed_sel = '0;
    count_next  = count;
    case (cmd_hold)
      CMD_INSERT: begin
        if (count == CW'(DEPTH)) begin
          status_sel = STAT_FULL;
        end else begin
          upd.insert = 1'b1;
          pos_sel    = scan_pos;
          count_next = count + 1'b1;
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_VALUE: begin
        if (count == '0) begin
          status_sel = STAT_EMPTY;
        end else if (!any) begin
          status_sel = STAT_NOT_FOUND;
        end else begin
          upd.remove  = 1'b1;
          pos_sel     = scan_pos;
          removed_sel = scan_value;
          count_next  = count - 1'b1;
        end
      end
      CMD_FIND: begin
        if (count == '0) begin
          status_sel = STAT_EMPTY;
        end else if (!any) begin
          status_sel = STAT_NOT_FOUND;
        end else begin
          pos_sel = scan_pos;
        end
      end
      default: begin
        status_sel = STAT_OK;
      end
    endcase
    if (!apply_go) begin
      upd        = '0;
      count_next = count;
    end
  end

  assign pos_wide = {{POS_W{1'b0}}, pos_sel};
  assign len_wide = {{LEN_W{1'b0}}, count_next};

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (apply_go) begin
      count <= count_next;
    end
  end

  // Result register; a new item may be taken while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (apply_go) begin
      rsp_valid <= 1'b1;
    end else if (response.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (apply_go) begin
      rsp_status   <= status_sel;
      rsp_removed  <= removed_sel;
      rsp_position <= pos_wide[POS_W-1:0];
      rsp_length   <= len_wide[LEN_W-1:0];
    end
  end

  assign response.valid         = rsp_valid;
  assign response.status        = rsp_status;
  assign response.removed_value = rsp_removed;
  assign response.position      = rsp_position;
  assign response.length        = rsp_length;

  // The count never passes the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

  // At most one cell is chosen by the scan.
  a_first_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(first))
    else $error("more than one cell chosen");

  // A result only appears after an apply step.
  a_rsp_after_apply: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_APPLY))
    else $error("result without apply step");

  // A successful insert grows the list by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    upd.insert |=> count == $past(count + 1'b1))
    else $error("insert did not grow the count");

  // Nothing is applied while an item is awaited.
  a_no_apply_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (upd == '0))
    else $error("cells shifted while idle");

endmodule

@@ rtl/sle_cell.sv @@
// One cell of the list chain: holds one entry and its compare flag.
// Depends on sle_pkg for command codes and the shift order struct.
module sle_cell import sle_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  cmd_t                    command,
  input  logic signed [VAL_W-1:0] key,
  input  logic                    descending,
  input  logic                    valid,
  input  logic                    valid_right,
  input  cell_upd_t               upd,
  input  logic                    first,
  input  logic                    incl,
  input  logic signed [VAL_W-1:0] left_value,
  input  logic signed [VAL_W-1:0] right_value,
  input  logic signed [VAL_W-1:0] ins_value,
  output logic signed [VAL_W-1:0] value,
  output logic                    flag
);

  logic flag_next;
  logic order_hit;

  // An insert lands ahead of the first entry not on the near side of the key.
  assign order_hit = descending ? (value <= key) : (value >= key);

  // Compare the broadcast key with this entry for the incoming command.
  always_comb begin
    case (command)
      CMD_INSERT:    flag_next = !valid || order_hit;
      CMD_REM_HEAD:  flag_next = valid;
      CMD_REM_TAIL:  flag_next = valid && !valid_right;
      CMD_REM_VALUE: flag_next = valid && (value == key);
      CMD_FIND:      flag_next = valid && (value == key);
      default:       flag_next = 1'b0;
    endcase
  end

  // The flag is captured when an item is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (load) begin
      flag <= flag_next;
    end
  end

  // Cells at or beyond the chosen place shift towards the tail or the head.
  always_ff @(posedge clk) begin
    if (upd.insert && incl) begin
      value <= first ? ins_value : left_value;
    end else if (upd.remove && incl) begin
      value <= right_value;
    end
  end

endmodule

@@ rtl/sle_scan.sv @@
// Scan across the cell flags: first hit, cells at or after it, its index and entry.
// Depends on sle_pkg for the value width.
module sle_scan import sle_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic [DEPTH-1:0]                flags,
  input  logic signed [VAL_W-1:0]         values [DEPTH],
  output logic [DEPTH-1:0]                first,
  output logic [DEPTH-1:0]                incl,
  output logic                            any,
  output logic [$clog2(DEPTH)-1:0]        position,
  output logic signed [VAL_W-1:0]         hit_value
);

  localparam int IW = $clog2(DEPTH);

  logic [DEPTH-1:0] prefix;

  // Log-depth prefix OR: bit i is set when any flag at index i or below is set.
  always_comb begin
    prefix = flags;
    for (int k = 0; k < IW; k++) begin
      prefix = prefix | (prefix << (1 << k));
    end
  end

  assign incl  = prefix;
  assign first = flags & ~(prefix << 1);
  assign any   = prefix[DEPTH-1];

  // The first hit is one-hot, so its index and entry are simple OR reductions.
  always_comb begin
    position  = '0;
    hit_value = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        position  = position | IW'(i);
        hit_value = hit_value | values[i];
      end
    end
  end

endmodule
